// File: design/lott_pkg.sv
// lott_pkg: shared types and constants for the lru object tag table
// request/result word structs, controller command/status structs, defaults
// no dependencies
`timescale 1ns / 1ps
`default_nettype none

package lott_pkg;

   localparam int SLOTS_DEF    = 10;
   localparam int KEY_BITS_DEF = 64;

   localparam int KEY_W   = 64;
   localparam int LEN_W   = 20;
   localparam int SLOT_W  = 4;
   localparam int TOTAL_W = 24;
   localparam int STAMP_W = 32;

   localparam logic [LEN_W-1:0] MAX_OBJECT_RESET = 20'd102400;

   localparam logic KIND_LOOKUP = 1'b0;
   localparam logic KIND_INSERT = 1'b1;

   typedef struct packed {
      logic             kind;
      logic [KEY_W-1:0] key;
      logic [LEN_W-1:0] object_bytes;
   } lott_req_type;

   typedef struct packed {
      logic               hit;
      logic               stored;
      logic [SLOT_W-1:0]  slot;
      logic [LEN_W-1:0]   entry_bytes;
      logic [TOTAL_W-1:0] total_bytes;
   } lott_rsp_type;

   typedef struct packed {
      logic load;
      logic step;
      logic commit;
   } lott_cmd_type;

   typedef struct packed {
      logic scan_last;
      logic out_free;
   } lott_sts_type;

endpackage

`default_nettype wire

// File: design/lott_ctrl.sv
// lott_ctrl: controller state machine for the tag table
// sequences capture, slot scan and table commit; uses lott_pkg
`timescale 1ns / 1ps
`default_nettype none

module lott_ctrl
   import lott_pkg::*;
(
   input  wire logic         clock,
   input  wire logic         reset,
   input  wire logic         req_valid,
   output      logic         req_stall,
   input  wire lott_sts_type sts,
   output      lott_cmd_type cmd
);

   typedef enum logic [2:0] {
      ST_IDLE   = 3'b001,
      ST_SCAN   = 3'b010,
      ST_COMMIT = 3'b100
   } state_type;

   state_type state_ff, state_in;

   always_comb begin
      state_in   = state_ff;
      cmd.load   = 1'b0;
      cmd.step   = 1'b0;
      cmd.commit = 1'b0;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = ST_SCAN;
            end
         end
         ST_SCAN: begin
            cmd.step = 1'b1;
            if (sts.scan_last) begin
               state_in = ST_COMMIT;
            end
         end
         ST_COMMIT: begin
            // wait until the result register can take a new word
            if (sts.out_free) begin
               cmd.commit = 1'b1;
               state_in   = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

   assign req_stall = (state_ff != ST_IDLE);

endmodule

`default_nettype wire

// File: design/lott_dp.sv
// lott_dp: datapath of the tag table: slot arrays, scan registers,
// use counter, byte total, size limit register and result register; uses lott_pkg
`timescale 1ns / 1ps
`default_nettype none

module lott_dp
   import lott_pkg::*;
#(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire lott_cmd_type     cmd,
   output      lott_sts_type     sts,
   input  wire lott_req_type     req_word,
   input  wire logic             csr_we,
   input  wire logic [LEN_W-1:0] csr_word,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lott_rsp_type     rsp_word
);

   localparam int               IDX_W = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam logic [IDX_W-1:0] LAST  = IDX_W'(SLOTS - 1);

   // slot table
   logic [KEY_BITS-1:0] key_ff   [SLOTS];
   logic [LEN_W-1:0]    len_ff   [SLOTS];
   logic [STAMP_W-1:0]  stamp_ff [SLOTS];

   logic [STAMP_W-1:0] counter_ff, counter_in;
   logic [TOTAL_W-1:0] bytes_ff, bytes_in;
   logic [LEN_W-1:0]   max_ff;

   // captured request
   logic                kind_ff;
   logic [KEY_BITS-1:0] qkey_ff;
   logic [LEN_W-1:0]    qlen_ff;

   // scan state
   logic [IDX_W-1:0]   idx_ff, idx_in;
   logic               found_ff, found_in;
   logic [IDX_W-1:0]   found_idx_ff, found_idx_in;
   logic [LEN_W-1:0]   found_len_ff, found_len_in;
   logic               empty_ff, empty_in;
   logic [IDX_W-1:0]   empty_idx_ff, empty_idx_in;
   logic [IDX_W-1:0]   best_idx_ff, best_idx_in;
   logic [STAMP_W-1:0] best_stamp_ff, best_stamp_in;
   logic [LEN_W-1:0]   best_len_ff, best_len_in;

   logic         rsp_valid_ff, rsp_valid_in;
   lott_rsp_type rsp_word_ff, rsp_word_in;

   // table write port
   logic                wr_en, wr_fill;
   logic [IDX_W-1:0]    wr_idx;

   logic [KEY_BITS-1:0] cur_key;
   logic [LEN_W-1:0]    cur_len;
   logic [STAMP_W-1:0]  cur_stamp;
   logic                ins_ok;
   logic [IDX_W-1:0]    victim_idx;
   logic [LEN_W-1:0]    victim_len;

   assign cur_key   = key_ff[idx_ff];
   assign cur_len   = len_ff[idx_ff];
   assign cur_stamp = stamp_ff[idx_ff];

   assign ins_ok     = (kind_ff == KIND_INSERT) && (qlen_ff <= max_ff);
   assign victim_idx = empty_ff ? empty_idx_ff : best_idx_ff;
   assign victim_len = empty_ff ? '0 : best_len_ff;

   always_comb begin
      idx_in        = idx_ff;
      found_in      = found_ff;
      found_idx_in  = found_idx_ff;
      found_len_in  = found_len_ff;
      empty_in      = empty_ff;
      empty_idx_in  = empty_idx_ff;
      best_idx_in   = best_idx_ff;
      best_stamp_in = best_stamp_ff;
      best_len_in   = best_len_ff;
      counter_in    = counter_ff;
      bytes_in      = bytes_ff;
      wr_en         = 1'b0;
      wr_fill       = 1'b0;
      wr_idx        = found_idx_ff;
      rsp_word_in   = rsp_word_ff;
      rsp_valid_in  = rsp_valid_ff && rsp_stall;

      if (cmd.load) begin
         idx_in   = '0;
         found_in = 1'b0;
         empty_in = 1'b0;
      end

      if (cmd.step) begin
         idx_in = idx_ff + 1'b1;
         // lowest matching slot wins
         if (!found_ff && (cur_key == qkey_ff)) begin
            found_in     = 1'b1;
            found_idx_in = idx_ff;
            found_len_in = cur_len;
         end
         if (!empty_ff && (cur_len == '0)) begin
            empty_in     = 1'b1;
            empty_idx_in = idx_ff;
         end
         // smallest signed stamp, strict compare keeps the lowest index on ties
         if ((idx_ff == '0) || ($signed(cur_stamp) < $signed(best_stamp_ff))) begin
            best_idx_in   = idx_ff;
            best_stamp_in = cur_stamp;
            best_len_in   = cur_len;
         end
      end

      if (cmd.commit) begin
         rsp_valid_in            = 1'b1;
         rsp_word_in.hit         = 1'b0;
         rsp_word_in.stored      = 1'b0;
         rsp_word_in.slot        = '0;
         rsp_word_in.entry_bytes = '0;
         if (kind_ff == KIND_LOOKUP) begin
            if (found_ff) begin
               counter_in              = counter_ff + 1'b1;
               wr_en                   = 1'b1;
               wr_idx                  = found_idx_ff;
               rsp_word_in.hit         = 1'b1;
               rsp_word_in.slot        = SLOT_W'(found_idx_ff);
               rsp_word_in.entry_bytes = found_len_ff;
            end
         end else if (ins_ok) begin
            counter_in              = counter_ff + 1'b1;
            bytes_in                = bytes_ff + TOTAL_W'(qlen_ff) - TOTAL_W'(victim_len);
            wr_en                   = 1'b1;
            wr_fill                 = 1'b1;
            wr_idx                  = victim_idx;
            rsp_word_in.stored      = 1'b1;
            rsp_word_in.slot        = SLOT_W'(victim_idx);
            rsp_word_in.entry_bytes = qlen_ff;
         end
         rsp_word_in.total_bytes = bytes_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         for (int i = 0; i < SLOTS; i++) begin
            key_ff[i]   <= '0;
            len_ff[i]   <= '0;
            stamp_ff[i] <= '0;
         end
         counter_ff   <= '0;
         bytes_ff     <= '0;
         max_ff       <= MAX_OBJECT_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (wr_en) begin
            stamp_ff[wr_idx] <= counter_in;
            if (wr_fill) begin
               key_ff[wr_idx] <= qkey_ff;
               len_ff[wr_idx] <= qlen_ff;
            end
         end
         if (csr_we) begin
            max_ff <= csr_word;
         end
         counter_ff   <= counter_in;
         bytes_ff     <= bytes_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (cmd.load) begin
         kind_ff <= req_word.kind;
         qkey_ff <= req_word.key[KEY_BITS-1:0];
         qlen_ff <= req_word.object_bytes;
      end
      idx_ff        <= idx_in;
      found_ff      <= found_in;
      found_idx_ff  <= found_idx_in;
      found_len_ff  <= found_len_in;
      empty_ff      <= empty_in;
      empty_idx_ff  <= empty_idx_in;
      best_idx_ff   <= best_idx_in;
      best_stamp_ff <= best_stamp_in;
      best_len_ff   <= best_len_in;
      rsp_word_ff   <= rsp_word_in;
   end

   assign sts.scan_last = (idx_ff == LAST);
   assign sts.out_free  = !rsp_valid_ff || !rsp_stall;

   assign rsp_valid = rsp_valid_ff;
   assign rsp_word  = rsp_word_ff;

endmodule

`default_nettype wire

// File: design/lru_object_tag_table_core.sv
// lru_object_tag_table_core: fully associative lru tag table, top level
// a request word is captured, then the scan reads one slot a cycle through a single key and
// stamp compare, then the table commit writes the result register; a new request is taken
// only when idle, so one is in flight at a time; a stalled result only holds off the table commit
// reset (synchronous): all slots cleared to key, length and stamp zero, use counter and
// byte total zero, object size limit back to 102400; depends on lott_pkg, lott_ctrl, lott_dp
`timescale 1ns / 1ps
`default_nettype none

module lru_object_tag_table_core
   import lott_pkg::*;
#(
   parameter int SLOTS    = SLOTS_DEF,
   parameter int KEY_BITS = KEY_BITS_DEF
) (
   input  wire logic             clock,
   input  wire logic             reset,
   input  wire logic             req_valid,
   output      logic             req_stall,
   input  wire lott_req_type     req_word,
   output      logic             rsp_valid,
   input  wire logic             rsp_stall,
   output      lott_rsp_type     rsp_word,
   input  wire logic             csr_valid,
   output      logic             csr_ready,
   input  wire logic [LEN_W-1:0] csr_word
);

   lott_cmd_type cmd;
   lott_sts_type sts;

   lott_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   lott_dp #(
      .SLOTS    (SLOTS),
      .KEY_BITS (KEY_BITS)
   ) u_dp (
      .clock     (clock),
      .reset     (reset),
      .cmd       (cmd),
      .sts       (sts),
      .req_word  (req_word),
      .csr_we    (csr_valid && csr_ready),
      .csr_word  (csr_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word)
   );

   // size limit is only written between requests
   assign csr_ready = !req_stall;

`ifndef SYNTH
   // an accepted word keeps the block busy through its scan
   a_busy_after_accept: assert property (@(posedge clock) disable iff (reset)
      (req_valid && !req_stall) |=> req_stall)
      else $error("request side not stalled after accept");

   // a fresh result only comes out of a busy block
   a_result_from_busy: assert property (@(posedge clock) disable iff (reset)
      $rose(rsp_valid) |-> $past(req_stall))
      else $error("result appeared without a request in flight");

   // a hit never also reports a store, and names a real slot
   a_hit_slot: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_word.hit) |-> (!rsp_word.stored && (rsp_word.slot < SLOTS)))
      else $error("bad hit result");
`endif

endmodule

`default_nettype wire

// File: tb/tb_lru_object_tag_table_core.sv
// tb_lru_object_tag_table_core: self-checking bench for the lru object tag table core
// drives lookup/insert words and size-limit writes, predicts every result word in order
// depends on lott_pkg and lru_object_tag_table_core
`timescale 1ns / 1ps

module tb_lru_object_tag_table_core;
   import lott_pkg::*;

   localparam int SLOTS       = SLOTS_DEF;
   localparam int HOLD_CYCLES = 400;
   localparam logic [KEY_W-1:0] KEY_MASK = {KEY_W{1'b1}} >> (KEY_W - KEY_BITS_DEF);
   localparam logic [LEN_W-1:0] LEN_MAX  = {LEN_W{1'b1}};

   logic             clock;
   logic             reset     = 1'b1;
   logic             req_valid = 1'b0;
   logic             req_stall;
   lott_req_type     req_word  = '0;
   logic             rsp_valid;
   logic             rsp_stall = 1'b0;
   lott_rsp_type     rsp_word;
   logic             csr_valid = 1'b0;
   logic             csr_ready;
   logic [LEN_W-1:0] csr_word  = '0;

   // predicted table contents
   logic [KEY_W-1:0]   tag_key   [SLOTS];
   logic [LEN_W-1:0]   tag_len   [SLOTS];
   logic [STAMP_W-1:0] tag_stamp [SLOTS];
   logic [STAMP_W-1:0] use_count;
   logic [TOTAL_W-1:0] held_bytes;
   logic [LEN_W-1:0]   size_limit;

   lott_rsp_type answers_due[$];
   logic [KEY_W-1:0] hot_keys[16];

   int  fail_count   = 0;
   int  lookups_seen = 0;
   int  inserts_seen = 0;
   int  hits_seen    = 0;
   int  drops_seen   = 0;
   int  limits_used  = 0;
   int  stall_left   = 0;
   bit  steady       = 1'b0;
   bit  hold_request = 1'b0;
   logic rsp_hold    = 1'b0;

   lru_object_tag_table_core i_dut (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .req_word  (req_word),
      .rsp_valid (rsp_valid),
      .rsp_stall (rsp_stall),
      .rsp_word  (rsp_word),
      .csr_valid (csr_valid),
      .csr_ready (csr_ready),
      .csr_word  (csr_word)
   );

   initial begin
      clock = 1'b0;
      forever #2 clock = ~clock;
   end

   initial begin
      #5_000_000;
      $display("Test completed with failures");
      $finish;
   end

   // mostly short gaps, a few long ones
   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (steady) return 0;
      if (r < 50) return 0;
      if (r < 85) return $urandom_range(1, 3);
      if (r < 97) return $urandom_range(4, 10);
      return $urandom_range(20, 60);
   endfunction

   function automatic lott_rsp_type predict_table_op(lott_req_type w);
      lott_rsp_type     a;
      logic [KEY_W-1:0] k;
      int               victim;
      a = '0;
      k = w.key & KEY_MASK;
      if (w.kind == KIND_LOOKUP) begin
         for (int s = 0; s < SLOTS; s++) begin
            if (!a.hit && tag_key[s] == k) begin
               a.hit         = 1'b1;
               a.slot        = SLOT_W'(s);
               a.entry_bytes = tag_len[s];
               use_count     = use_count + 1'b1;
               tag_stamp[s]  = use_count;
            end
         end
      end else if (w.object_bytes <= size_limit) begin
         victim = -1;
         for (int s = 0; s < SLOTS; s++)
            if (victim < 0 && tag_len[s] == '0) victim = s;
         // table full: oldest signed stamp, lowest index on ties
         if (victim < 0) begin
            victim = 0;
            for (int s = 1; s < SLOTS; s++)
               if ($signed(tag_stamp[s]) < $signed(tag_stamp[victim])) victim = s;
         end
         held_bytes        = held_bytes + w.object_bytes - tag_len[victim];
         tag_key[victim]   = k;
         tag_len[victim]   = w.object_bytes;
         use_count         = use_count + 1'b1;
         tag_stamp[victim] = use_count;
         a.stored          = 1'b1;
         a.slot            = SLOT_W'(victim);
         a.entry_bytes     = w.object_bytes;
      end
      a.total_bytes = held_bytes;
      return a;
   endfunction

   task automatic send_request(input logic kind, input logic [KEY_W-1:0] key,
                               input logic [LEN_W-1:0] len);
      lott_req_type w;
      int           gap;
      w.kind         = kind;
      w.key          = key;
      w.object_bytes = len;
      req_word  <= w;
      req_valid <= 1'b1;
      do @(posedge clock); while (req_stall);
      answers_due.push_back(predict_table_op(w));
      gap = pick_gap();
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
   endtask

   task automatic wait_idle();
      req_valid <= 1'b0;
      while (answers_due.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic set_size_limit(input logic [LEN_W-1:0] v);
      wait_idle();
      csr_word  <= v;
      csr_valid <= 1'b1;
      do @(posedge clock); while (!csr_ready);
      csr_valid <= 1'b0;
      size_limit = v;
      limits_used++;
   endtask

   function automatic logic [LEN_W-1:0] pick_length();
      int r;
      int v;
      r = $urandom_range(0, 99);
      if (r < 10) return '0;
      if (r < 45) return LEN_W'($urandom_range(1, 4096));
      if (r < 65) begin
         v = int'(size_limit) + $urandom_range(0, 4) - 2;
         if (v < 0) v = 0;
         if (v > int'(LEN_MAX)) v = int'(LEN_MAX);
         return LEN_W'(v);
      end
      if (r < 85) return LEN_W'($urandom_range(0, int'(size_limit)));
      return LEN_W'($urandom_range(0, int'(LEN_MAX)));
   endfunction

   function automatic logic [KEY_W-1:0] pick_key(input int hot_pct);
      if ($urandom_range(0, 99) < hot_pct) return hot_keys[$urandom_range(0, 15)];
      return {$urandom(), $urandom()};
   endfunction

   task automatic send_random(input int count);
      for (int i = 0; i < count; i++) begin
         if (i % 100 == 0) steady = ($urandom_range(0, 3) == 0);
         if ($urandom_range(0, 1) == 0)
            send_request(KIND_LOOKUP, pick_key(85), LEN_W'($urandom_range(0, int'(LEN_MAX))));
         else
            send_request(KIND_INSERT, pick_key(80), pick_length());
      end
      steady = 1'b0;
   endtask

   task automatic check_result(input lott_rsp_type exp, input lott_rsp_type got);
      if (got.hit !== exp.hit) begin
         $error("hit: expected %0h, actual %0h", exp.hit, got.hit);
         fail_count++;
      end
      if (got.stored !== exp.stored) begin
         $error("stored: expected %0h, actual %0h", exp.stored, got.stored);
         fail_count++;
      end
      if (got.slot !== exp.slot) begin
         $error("slot: expected %0d, actual %0d", exp.slot, got.slot);
         fail_count++;
      end
      if (got.entry_bytes !== exp.entry_bytes) begin
         $error("entry_bytes: expected %0d, actual %0d", exp.entry_bytes, got.entry_bytes);
         fail_count++;
      end
      if (got.total_bytes !== exp.total_bytes) begin
         $error("total_bytes: expected %0d, actual %0d", exp.total_bytes, got.total_bytes);
         fail_count++;
      end
   endtask

   // result side: compare each accepted word, then pick the next stall
   always @(posedge clock) begin : result_check
      lott_rsp_type exp;
      bit           busy;
      busy = 1'b0;
      if (!reset && rsp_valid && !rsp_stall) begin
         if (answers_due.size() == 0) begin
            $error("result word with nothing expected: %h", rsp_word);
            fail_count++;
         end else begin
            exp = answers_due.pop_front();
            check_result(exp, rsp_word);
            if (exp.hit) hits_seen++;
         end
      end
      if (stall_left == 0 && !steady && $urandom_range(0, 99) < 15)
         stall_left = 1 + pick_gap();
      if (stall_left > 0) begin
         busy = 1'b1;
         stall_left--;
      end
      rsp_stall <= rsp_hold || busy;
   end

   // long receiver hold-off, counted here
   initial begin : receiver_hold
      forever begin
         wait (hold_request);
         @(posedge clock);
         rsp_hold <= 1'b1;
         repeat (HOLD_CYCLES) @(posedge clock);
         rsp_hold <= 1'b0;
         hold_request = 1'b0;
      end
   end

   // count request kinds as they are accepted
   always @(posedge clock) begin
      if (!reset && req_valid && !req_stall) begin
         if (req_word.kind == KIND_LOOKUP) lookups_seen++;
         else if (req_word.object_bytes <= size_limit) inserts_seen++;
         else drops_seen++;
      end
   end

   task automatic test_empty_slot_match();
      send_request(KIND_LOOKUP, '0, '0);
      send_request(KIND_LOOKUP, 64'h0000_0000_0000_1234, LEN_MAX);
      send_request(KIND_LOOKUP, '0, 20'h5A5A5);
   endtask

   task automatic test_size_limit_edges();
      send_request(KIND_INSERT, 64'hA5A5_0000_0000_0001, MAX_OBJECT_RESET);
      send_request(KIND_INSERT, 64'hA5A5_0000_0000_0002, MAX_OBJECT_RESET + 1'b1);
      // zero length leaves the slot counted as empty
      send_request(KIND_INSERT, 64'hA5A5_0000_0000_0003, '0);
      send_request(KIND_LOOKUP, 64'hA5A5_0000_0000_0003, '0);
      send_request(KIND_INSERT, 64'hA5A5_0000_0000_0004, 20'd5);
      // same key twice, lookup must return the lower slot
      send_request(KIND_INSERT, 64'hA5A5_0000_0000_0001, 20'd7);
      send_request(KIND_LOOKUP, 64'hA5A5_0000_0000_0001, '0);
      send_request(KIND_LOOKUP, 64'hA5A5_0000_0000_0002, '0);
   endtask

   task automatic test_lru_replacement();
      for (int i = 0; i < SLOTS - 3; i++)
         send_request(KIND_INSERT, 64'h100 + i, LEN_W'(100 * (i + 1)));
      send_request(KIND_LOOKUP, 64'hA5A5_0000_0000_0001, '0);
      for (int i = 0; i < 3; i++)
         send_request(KIND_INSERT, 64'h200 + i, LEN_W'(3 + i));
   endtask

   task automatic test_limit_extremes();
      set_size_limit('0);
      send_request(KIND_INSERT, 64'hFEED_0000_0000_0000, '0);
      send_request(KIND_INSERT, 64'hFEED_0000_0000_0001, 20'd1);
      send_request(KIND_LOOKUP, 64'hFEED_0000_0000_0000, '0);
      set_size_limit(LEN_MAX);
      send_request(KIND_INSERT, 64'h8000_0000_0000_0000, LEN_MAX);
      send_request(KIND_INSERT, {KEY_W{1'b1}}, LEN_MAX);
      send_request(KIND_LOOKUP, {KEY_W{1'b1}}, '0);
   endtask

   task automatic test_random_phases();
      set_size_limit(MAX_OBJECT_RESET);
      send_random(650);
      set_size_limit(LEN_MAX);
      send_random(400);
      set_size_limit('0);
      send_random(100);
      set_size_limit(LEN_W'($urandom_range(1, int'(LEN_MAX))));
      send_random(300);
      set_size_limit(20'd4095);
      send_random(300);
   endtask

   task automatic test_backpressure();
      wait_idle();
      hold_request = 1'b1;
      steady       = 1'b1;
      for (int i = 0; i < 40; i++) begin
         if (i % 2 == 0) send_request(KIND_INSERT, pick_key(80), pick_length());
         else send_request(KIND_LOOKUP, pick_key(90), '0);
      end
      steady = 1'b0;
   endtask

   initial begin
      for (int s = 0; s < SLOTS; s++) begin
         tag_key[s]   = '0;
         tag_len[s]   = '0;
         tag_stamp[s] = '0;
      end
      use_count  = '0;
      held_bytes = '0;
      size_limit = MAX_OBJECT_RESET;
      hot_keys[0] = '0;
      hot_keys[1] = {KEY_W{1'b1}};
      hot_keys[2] = 64'h8000_0000_0000_0000;
      for (int i = 3; i < 16; i++) hot_keys[i] = {$urandom(), $urandom()};

      repeat (12) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);

      test_empty_slot_match();
      test_size_limit_edges();
      test_lru_replacement();
      test_limit_extremes();
      test_random_phases();
      test_backpressure();

      wait_idle();
      repeat (20) @(posedge clock);
      $display("Covered %0d lookups (%0d hits), %0d stored and %0d oversize inserts",
               lookups_seen, hits_seen, inserts_seen, drops_seen);
      $display("across %0d size-limit writes, with random gaps, stalls and a long hold-off",
               limits_used);
      if (fail_count == 0 && answers_due.size() == 0)
         $display("Test completed successfully");
      else
         $display("Test completed with failures");
      $finish;
   end

endmodule
